// ===== rtl/kbch_pkg.sv =====
package kbch_pkg;

   localparam int unsigned KeyByteWidth   = 8;
   localparam int unsigned WordWidth      = 32;
   localparam int unsigned CodeWidth      = 31;
   localparam int unsigned SizeWidth      = 27;
   localparam int unsigned DivSteps       = CodeWidth;
   localparam int unsigned DivCountWidth  = $clog2(DivSteps);

   localparam logic [WordWidth-1:0] RsMultInit = 32'd63689;
   localparam logic [WordWidth-1:0] RsMultStep = 32'd378551;
   localparam logic [WordWidth-1:0] BkdrSeed   = 32'd131;
   localparam logic [SizeWidth-1:0] SizeReset  = 27'd433;
   localparam logic [DivCountWidth-1:0] DivLastCount = DivCountWidth'(DivSteps - 1);

   typedef struct packed {
      logic [KeyByteWidth-1:0] key_byte;
      logic                    last_byte;
   } req_type;

   typedef struct packed {
      logic [SizeWidth-1:0] bucket_index;
      logic [CodeWidth-1:0] key_code;
   } rsp_type;

   typedef struct packed {
      logic hash_step;
      logic load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ===== rtl/kbch_datapath.sv =====
module kbch_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  kbch_pkg::cmd_type                cmd,
   output kbch_pkg::status_type             status,
   input  kbch_pkg::req_type                req_data,
   input  logic                             csr_write,
   input  logic [kbch_pkg::SizeWidth-1:0]   csr_data,
   output kbch_pkg::rsp_type                rsp_data
);

   logic [kbch_pkg::WordWidth-1:0]     rs_acc_ff, rs_acc_in;
   logic [kbch_pkg::WordWidth-1:0]     rs_mult_ff, rs_mult_in;
   logic [kbch_pkg::WordWidth-1:0]     bkdr_acc_ff, bkdr_acc_in;
   logic [kbch_pkg::SizeWidth-1:0]     table_size_ff, table_size_in;
   logic [kbch_pkg::SizeWidth-1:0]     divisor_ff, divisor_in;
   logic [kbch_pkg::SizeWidth-1:0]     rem_ff, rem_in;
   logic [kbch_pkg::CodeWidth-1:0]     dvd_ff, dvd_in;
   logic [kbch_pkg::CodeWidth-1:0]     code_ff, code_in;
   logic [kbch_pkg::DivCountWidth-1:0] cnt_ff, cnt_in;
   kbch_pkg::rsp_type                  out_ff, out_in;

   logic [kbch_pkg::WordWidth-1:0] byte_ext;
   logic [kbch_pkg::WordWidth-1:0] rs_prod;
   logic [kbch_pkg::WordWidth-1:0] mult_prod;
   logic [kbch_pkg::WordWidth-1:0] bkdr_prod;
   logic [kbch_pkg::SizeWidth:0]   rem_shift;
   logic [kbch_pkg::SizeWidth:0]   rem_diff;

   assign byte_ext  = {{(kbch_pkg::WordWidth - kbch_pkg::KeyByteWidth){req_data.key_byte[7]}},
                       req_data.key_byte};
   assign rs_prod   = rs_acc_ff * rs_mult_ff;
   assign mult_prod = rs_mult_ff * kbch_pkg::RsMultStep;
   assign bkdr_prod = bkdr_acc_ff * kbch_pkg::BkdrSeed;

   // restoring divider, one quotient bit per step
   assign rem_shift = {rem_ff, dvd_ff[kbch_pkg::CodeWidth-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      rs_acc_in     = rs_acc_ff;
      rs_mult_in    = rs_mult_ff;
      bkdr_acc_in   = bkdr_acc_ff;
      table_size_in = table_size_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      code_in       = code_ff;
      cnt_in        = cnt_ff;
      out_in        = out_ff;
      if (csr_write) begin
         table_size_in = csr_data;
      end
      if (cmd.hash_step) begin
         rs_acc_in   = rs_prod + byte_ext;
         rs_mult_in  = mult_prod;
         bkdr_acc_in = bkdr_prod + byte_ext;
      end
      if (cmd.load) begin
         divisor_in  = table_size_ff;
         rem_in      = '0;
         dvd_in      = rs_acc_ff[kbch_pkg::CodeWidth-1:0];
         code_in     = bkdr_acc_ff[kbch_pkg::CodeWidth-1:0];
         cnt_in      = '0;
         rs_acc_in   = '0;
         rs_mult_in  = kbch_pkg::RsMultInit;
         bkdr_acc_in = '0;
      end
      if (cmd.div_step) begin
         if (rem_shift >= {1'b0, divisor_ff}) begin
            rem_in = rem_diff[kbch_pkg::SizeWidth-1:0];
         end else begin
            rem_in = rem_shift[kbch_pkg::SizeWidth-1:0];
         end
         dvd_in = {dvd_ff[kbch_pkg::CodeWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         out_in.bucket_index = (divisor_ff == '0) ? '0 : rem_ff;
         out_in.key_code     = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_acc_ff     <= '0;
         rs_mult_ff    <= kbch_pkg::RsMultInit;
         bkdr_acc_ff   <= '0;
         table_size_ff <= kbch_pkg::SizeReset;
      end else begin
         rs_acc_ff     <= rs_acc_in;
         rs_mult_ff    <= rs_mult_in;
         bkdr_acc_ff   <= bkdr_acc_in;
         table_size_ff <= table_size_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      code_ff    <= code_in;
      cnt_ff     <= cnt_in;
      out_ff     <= out_in;
   end

   assign status.div_last = (cnt_ff == kbch_pkg::DivLastCount);
   assign rsp_data        = out_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && divisor_ff != '0 && rem_ff < divisor_ff |=> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   a_load_clears_hashes: assert property (@(posedge clock) disable iff (reset)
      cmd.load && !csr_write |=> rs_acc_ff == '0 && bkdr_acc_ff == '0 &&
      rs_mult_ff == kbch_pkg::RsMultInit && cnt_ff == '0)
      else $error("hash state not cleared at end of key");

   a_zero_size_bucket: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && divisor_ff == '0 |=> rsp_data.bucket_index == '0)
      else $error("zero table size gave a nonzero bucket");

endmodule

// ===== rtl/kbch_control.sv =====
module kbch_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  kbch_pkg::status_type  status,
   output kbch_pkg::cmd_type     cmd
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StLoad = 2'd1;
   localparam logic [1:0] StDiv  = 2'd2;
   localparam logic [1:0] StHold = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != StIdle);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               cmd.hash_step = 1'b1;
               if (req_last) begin
                  state_in = StLoad;
               end
            end
         end
         StLoad: begin
            cmd.load = 1'b1;
            state_in = StDiv;
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = StHold;
            end
         end
         StHold: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_last_starts_load: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> state_ff == StLoad)
      else $error("last byte did not start the divide");

   a_load_then_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == StLoad |=> state_ff == StDiv && !cmd.out_load)
      else $error("load not followed by divide");

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff && state_ff == StIdle)
      else $error("result load did not raise valid");

endmodule

// ===== rtl/key_bucket_and_code_hash_core.sv =====
// Key bytes arrive one per transaction, with last_byte marking the end of a
// key; each byte updates the RS and BKDR hashes as it is accepted. The final
// byte is followed by a busy period (a load state, 31 steps of the serial
// restoring divider that forms the bucket index, and a hold state that loads
// the output register). A result held in the output register while rsp_stall
// is high delays the load of the next result and keeps req_stall high.
// table_size may be written whenever no key is in flight.
module key_bucket_and_code_hash_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  kbch_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output kbch_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kbch_pkg::SizeWidth-1:0] csr_data
);

   kbch_pkg::cmd_type    cmd;
   kbch_pkg::status_type status;

   assign csr_ready = 1'b1;

   kbch_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_byte),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kbch_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb.sv =====
module tb;

   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 60;
   localparam int PressureCycles = 300;

   typedef enum logic {
      ROW_BYTE,
      ROW_SIZE
   } row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [kbch_pkg::SizeWidth-1:0] value;
      logic                           last_byte;
      logic                           typed;
      logic [kbch_pkg::SizeWidth-1:0] want_bucket;
      logic [kbch_pkg::CodeWidth-1:0] want_code;
   } dir_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   kbch_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   kbch_pkg::rsp_type              rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [kbch_pkg::SizeWidth-1:0] csr_data = '0;

   // hash state mirrored from the block
   logic [kbch_pkg::WordWidth-1:0] rs_sum = '0;
   logic [kbch_pkg::WordWidth-1:0] rs_scale = kbch_pkg::RsMultInit;
   logic [kbch_pkg::WordWidth-1:0] bkdr_sum = '0;
   logic [kbch_pkg::SizeWidth-1:0] buckets = kbch_pkg::SizeReset;

   kbch_pkg::rsp_type pending_hashes[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   logic    pressure_go = 1'b0;
   logic    pressure_taken = 1'b0;
   int      hold_left = 0;

   dir_row_type directed_rows [25] = '{
      '{ROW_BYTE, 27'h00, 1'b1, 1'b1, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h01, 1'b1, 1'b1, 27'd1, 31'd1},
      '{ROW_BYTE, 27'h7F, 1'b1, 1'b1, 27'd127, 31'd127},
      '{ROW_BYTE, 27'h80, 1'b1, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'hFF, 1'b1, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'hFF, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'hFF, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'hFF, 1'b1, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h80, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h7F, 1'b1, 1'b0, 27'd0, 31'd0},
      '{ROW_SIZE, 27'd0, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h05, 1'b1, 1'b1, 27'd0, 31'd5},
      '{ROW_BYTE, 27'h41, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h42, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h43, 1'b1, 1'b0, 27'd0, 31'd0},
      '{ROW_SIZE, 27'd1, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h7F, 1'b1, 1'b1, 27'd0, 31'd127},
      '{ROW_SIZE, 27'h7FFFFFF, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'hFF, 1'b1, 1'b1, 27'd15, 31'h7FFFFFFF},
      '{ROW_BYTE, 27'h01, 1'b1, 1'b1, 27'd1, 31'd1},
      '{ROW_SIZE, 27'd101198593, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h12, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'h34, 1'b0, 1'b0, 27'd0, 31'd0},
      '{ROW_BYTE, 27'hFE, 1'b1, 1'b0, 27'd0, 31'd0},
      '{ROW_SIZE, 27'd433, 1'b0, 1'b0, 27'd0, 31'd0}
   };

   key_bucket_and_code_hash_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("** key_bucket_and_code_hash_core: FAILED **");
         $finish;
      end
   end

   task automatic log_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
      if (mismatch_count < 100) begin
         $display("mismatch %s: got %0d expected %0d", field, got, want);
      end
      mismatch_count++;
   endtask

   // advances both hashes by one key byte; on the last byte forms the result
   task automatic absorb_key_byte(input kbch_pkg::req_type item, output logic done,
                                  output kbch_pkg::rsp_type result);
      logic [kbch_pkg::WordWidth-1:0] byte_word;
      logic [kbch_pkg::WordWidth-1:0] rs_low;
      byte_word = {{(kbch_pkg::WordWidth - kbch_pkg::KeyByteWidth)
                    {item.key_byte[kbch_pkg::KeyByteWidth-1]}},
                   item.key_byte};
      rs_sum = rs_sum * rs_scale + byte_word;
      rs_scale = rs_scale * kbch_pkg::RsMultStep;
      bkdr_sum = bkdr_sum * kbch_pkg::BkdrSeed + byte_word;
      done = item.last_byte;
      result = '0;
      if (item.last_byte) begin
         rs_low = {1'b0, rs_sum[kbch_pkg::CodeWidth-1:0]};
         if (buckets != '0) begin
            result.bucket_index = kbch_pkg::SizeWidth'(rs_low % {5'b0, buckets});
         end
         result.key_code = bkdr_sum[kbch_pkg::CodeWidth-1:0];
         rs_sum = '0;
         rs_scale = kbch_pkg::RsMultInit;
         bkdr_sum = '0;
      end
   endtask

   task automatic check_hash_result(input kbch_pkg::rsp_type got);
      kbch_pkg::rsp_type want;
      if (pending_hashes.size() == 0) begin
         log_mismatch("unexpected transaction, key_code", 32'(got.key_code), 32'd0);
         return;
      end
      want = pending_hashes.pop_front();
      if (got.bucket_index !== want.bucket_index) begin
         log_mismatch("bucket_index", 32'(got.bucket_index), 32'(want.bucket_index));
      end
      if (got.key_code !== want.key_code) begin
         log_mismatch("key_code", 32'(got.key_code), 32'(want.key_code));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_hash_result(rsp_data);
         end
         if (pressure_go && !pressure_taken) begin
            pressure_taken = 1'b1;
            hold_left = PressureCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // leaves req_valid high after the transaction; the caller lowers it
   task automatic push_byte(input kbch_pkg::req_type item, input logic typed,
                            input kbch_pkg::rsp_type want);
      logic              done;
      kbch_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_key_byte(item, done, predicted);
      if (done) begin
         pending_hashes.push_back(typed ? want : predicted);
      end
   endtask

   task automatic write_table_size(input logic [kbch_pkg::SizeWidth-1:0] size);
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      buckets = size;
   endtask

   task automatic run_random_keys(input int n_bytes);
      int                sent;
      int                len;
      kbch_pkg::req_type item;
      sent = 0;
      while (sent < n_bytes) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         for (int k = 0; k < len; k++) begin
            item.key_byte = kbch_pkg::KeyByteWidth'($urandom_range(255));
            if ($urandom_range(7) == 0) begin
               // push toward 0x00, 0x7f, 0x80, 0xff
               item.key_byte = {item.key_byte[7], {7{item.key_byte[6]}}};
            end
            item.last_byte = (k == len - 1);
            push_byte(item, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      dir_row_type       row;
      kbch_pkg::req_type item;
      kbch_pkg::rsp_type want;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_SIZE) begin
            write_table_size(row.value);
         end else begin
            item.key_byte = row.value[kbch_pkg::KeyByteWidth-1:0];
            item.last_byte = row.last_byte;
            want.bucket_index = row.want_bucket;
            want.key_code = row.want_code;
            push_byte(item, row.typed, want);
         end
      end

      write_table_size(kbch_pkg::SizeWidth'($urandom_range(27'h7FFFFFF, 2)));
      send_idle_pct = 9;
      recv_idle_pct = 81;
      run_random_keys(300);

      write_table_size(kbch_pkg::SizeWidth'($urandom_range(500, 1)));
      send_idle_pct = 81;
      recv_idle_pct = 9;
      run_random_keys(300);

      write_table_size(27'd101198593);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pressure_go <= 1'b1;
      run_random_keys(300);

      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_hashes.size() == 0) begin
         $display("** key_bucket_and_code_hash_core: PASSED **");
      end else begin
         $display("** key_bucket_and_code_hash_core: FAILED **");
      end
      $finish;
   end

endmodule
